>>> rtl/srpt_pkg.sv
// ----------------------------------------------------------------------------
// SRPT scheduler package
// Shared widths, the job slot record and the table control bundle.
// ----------------------------------------------------------------------------
package srpt_pkg;

  localparam int unsigned IdW          = 8;
  localparam int unsigned LenW         = 16;
  localparam int unsigned WaitW        = 16;
  localparam int unsigned DefaultDepth = 16;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [LenW-1:0]  rem;
    logic [WaitW-1:0] wait_cnt;
  } slot_t;

  // bank: 0 reads bank 0 and writes bank 1, 1 the other way round
  typedef struct packed {
    logic bank;
    logic wr_en;
  } tbl_ctrl_t;

  function automatic logic [WaitW-1:0] sat_inc(input logic [WaitW-1:0] v);
    return (&v) ? v : v + WaitW'(1);
  endfunction

endpackage

>>> rtl/srpt_table.sv
// ----------------------------------------------------------------------------
// SRPT job table
// Two ping-pong slot banks: one is read in order while the updated table is
// written into the other. One read and one write address per cycle.
// ----------------------------------------------------------------------------
module srpt_table
  import srpt_pkg::*;
#(
  parameter int unsigned TableDepth = DefaultDepth,
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  logic            clk_i,
  input  tbl_ctrl_t       ctrl_i,
  input  logic [IdxW-1:0] rd_addr_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  slot_t           wr_data_i,
  output slot_t           rd_data_o
);

  slot_t bank0_q [TableDepth];
  slot_t bank1_q [TableDepth];
  slot_t rd0_q;
  slot_t rd1_q;

  always_ff @(posedge clk_i) begin
    rd0_q <= bank0_q[rd_addr_i];
    rd1_q <= bank1_q[rd_addr_i];
    if (ctrl_i.wr_en) begin
      if (ctrl_i.bank) begin
        bank0_q[wr_addr_i] <= wr_data_i;
      end else begin
        bank1_q[wr_addr_i] <= wr_data_i;
      end
    end
  end

  assign rd_data_o = ctrl_i.bank ? rd1_q : rd0_q;

endmodule

>>> rtl/srpt_scheduler_core.sv
// ----------------------------------------------------------------------------
// SRPT scheduler core
// Shortest-remaining-time job table, one scheduler tick per input item.
//
// Input channel (s_axis): one item per tick, carrying an optional arriving
// job (arrival_valid, job_id, job_len). Output channel (m_axis): one item per
// tick with the running job, a finished job with its wait count, the number
// of jobs left in the table and a drop flag for an arrival into a full table.
// A tick walks the table once: each cycle one stored slot or the arrival is
// merged into the updated table in the other bank. The walk covers the jobs
// held before the tick and the arrival when it is stored; a finishing state
// then puts the result into the output register.
// The walk is set by the single table read port.
// s_axis_tready_o is low while a tick is being walked; the next item is
// accepted as soon as the result sits in the output register, even if the
// receiver has not taken it. A stalled receiver holds the result and stops
// the following tick from completing.
// Reset empties the table; slot contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module srpt_scheduler_core
  import srpt_pkg::*;
#(
  parameter int unsigned TableDepth = DefaultDepth,
  localparam int unsigned CntW      = $clog2(TableDepth + 1),
  localparam int unsigned InFieldsW = 1 + IdW + LenW,
  localparam int unsigned InW       = ((InFieldsW + 7) / 8) * 8,
  localparam int unsigned OutFieldsW = 1 + IdW + 1 + IdW + WaitW + CntW + 1,
  localparam int unsigned OutW      = ((OutFieldsW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // arrival_valid, job_id, job_len
  input  logic [InW-1:0]  s_axis_tdata_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // running_valid, running_id, done_valid, done_id, done_wait,
  // queued_count, arrival_dropped
  output logic [OutW-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic            bank_q, bank_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pend_q, pend_d;
  logic            head_q, head_d;
  logic            out_valid_q, out_valid_d;

  logic [CntW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IdW-1:0]   arr_id_q, arr_id_d;
  logic [LenW-1:0]  arr_len_q, arr_len_d;
  logic             run_v_q, run_v_d;
  logic [IdW-1:0]   run_id_q, run_id_d;
  logic             done_v_q, done_v_d;
  logic [IdW-1:0]   done_id_q, done_id_d;
  logic [WaitW-1:0] done_wait_q, done_wait_d;
  logic             drop_q, drop_d;
  logic [OutW-1:0]  out_data_q, out_data_d;

  logic            in_arrive;
  logic [IdW-1:0]  in_id;
  logic [LenW-1:0] in_len;
  logic            in_real;
  logic            has_room;

  slot_t           rd_slot;
  slot_t           elem;
  slot_t           wr_slot;
  logic            wr_en;
  logic            take_arr;
  logic            walk_end;
  logic [LenW-1:0] rem_dec;
  tbl_ctrl_t       tbl_ctrl;

  assign in_arrive = s_axis_tdata_i[0];
  assign in_id     = s_axis_tdata_i[IdW:1];
  assign in_len    = s_axis_tdata_i[IdW+LenW:IdW+1];
  assign in_real   = in_arrive && (in_len != '0);
  assign has_room  = count_q < CntW'(TableDepth);

  assign walk_end = !pend_q && (rd_ptr_q == count_q);
  assign take_arr = pend_q && ((rd_ptr_q == count_q) ||
                    (head_q ? (arr_len_q < rd_slot.rem) : (arr_len_q <= rd_slot.rem)));
  assign elem     = take_arr ? slot_t'{id: arr_id_q, rem: arr_len_q, wait_cnt: '0} : rd_slot;
  assign rem_dec  = elem.rem - LenW'(1);

  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    count_d     = count_q;
    pend_d      = pend_q;
    head_d      = head_q;
    out_valid_d = out_valid_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    arr_id_d    = arr_id_q;
    arr_len_d   = arr_len_q;
    run_v_d     = run_v_q;
    run_id_d    = run_id_q;
    done_v_d    = done_v_q;
    done_id_d   = done_id_q;
    done_wait_d = done_wait_q;
    drop_d      = drop_q;
    out_data_d  = out_data_q;
    wr_en       = 1'b0;
    wr_slot     = elem;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          pend_d      = in_real && has_room;
          drop_d      = in_real && !has_room;
          arr_id_d    = in_id;
          arr_len_d   = in_len;
          rd_ptr_d    = '0;
          wr_ptr_d    = '0;
          head_d      = 1'b1;
          run_v_d     = 1'b0;
          run_id_d    = '0;
          done_v_d    = 1'b0;
          done_id_d   = '0;
          done_wait_d = '0;
          state_d     = StWalk;
        end
      end
      StWalk: begin
        if (walk_end) begin
          state_d = StFin;
        end else begin
          if (take_arr) begin
            pend_d = 1'b0;
          end else begin
            rd_ptr_d = rd_ptr_q + CntW'(1);
          end
          if (head_q) begin
            head_d   = 1'b0;
            run_v_d  = 1'b1;
            run_id_d = elem.id;
            if (rem_dec == '0) begin
              done_v_d    = 1'b1;
              done_id_d   = elem.id;
              done_wait_d = elem.wait_cnt;
            end else begin
              wr_en    = 1'b1;
              wr_slot  = '{id: elem.id, rem: rem_dec, wait_cnt: elem.wait_cnt};
              wr_ptr_d = wr_ptr_q + CntW'(1);
            end
          end else begin
            wr_en    = 1'b1;
            wr_slot  = '{id: elem.id, rem: elem.rem, wait_cnt: sat_inc(elem.wait_cnt)};
            wr_ptr_d = wr_ptr_q + CntW'(1);
          end
        end
      end
      StFin: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = OutW'({drop_q, wr_ptr_q, done_wait_q, done_id_q, done_v_q,
                               run_id_q, run_v_q});
          count_d     = wr_ptr_q;
          bank_d      = ~bank_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign tbl_ctrl = '{bank: bank_q, wr_en: wr_en};

  srpt_table #(
    .TableDepth(TableDepth)
  ) u_table (
    .clk_i    (clk_i),
    .ctrl_i   (tbl_ctrl),
    .rd_addr_i(rd_ptr_d[IdxW-1:0]),
    .wr_addr_i(wr_ptr_q[IdxW-1:0]),
    .wr_data_i(wr_slot),
    .rd_data_o(rd_slot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bank_q      <= 1'b0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      head_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q    <= rd_ptr_d;
    wr_ptr_q    <= wr_ptr_d;
    arr_id_q    <= arr_id_d;
    arr_len_q   <= arr_len_d;
    run_v_q     <= run_v_d;
    run_id_q    <= run_id_d;
    done_v_q    <= done_v_d;
    done_id_q   <= done_id_d;
    done_wait_q <= done_wait_d;
    drop_q      <= drop_d;
    out_data_q  <= out_data_d;
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
